>>> rtl/core/tcm_pkg.sv
`default_nettype none
package tcm_pkg;
	localparam int SamplesPerReading = 18;
	localparam int ChannelCount = 8;
	localparam int TableEntries = 146;
	localparam int ChanW = 3;
	localparam int SampleW = 12;
	localparam int TempW = 12;
	localparam int SumW = 17;
	localparam int IdxW = 8;
	localparam logic [TempW-1:0] TempCold = 12'hE70;
	localparam logic [TempW-1:0] TempHot = 12'd1050;
	localparam logic [1:0] RegThreshold = 2'd0;
	localparam logic [1:0] RegLimit = 2'd1;
	localparam logic [1:0] RegMask = 2'd2;

	typedef struct packed {
		logic [ChanW-1:0] channel;
		logic [SampleW-1:0] mean;
		logic armed;
	} group_t;

	function automatic logic [SampleW-1:0] ntc_entry(input logic [IdxW-1:0] i);
		logic [SampleW-1:0] t [0:145];
		t = '{
		3894,3883,3872,3860,3847,3835,3821,3807,3793,3778,
		3763,3747,3730,3712,3695,3676,3657,3637,3616,3595,
		3573,3550,3527,3503,3478,3453,3427,3400,3373,3345,
		3316,3287,3257,3226,3195,3164,3131,3099,3065,3032,
		2997,2963,2927,2892,2856,2819,2782,2745,2708,2670,
		2632,2593,2555,2516,2477,2438,2399,2360,2321,2281,
		2242,2203,2164,2125,2086,2048,2009,1971,1933,1895,
		1858,1821,1784,1748,1712,1677,1641,1607,1573,1539,
		1506,1473,1441,1409,1378,1347,1317,1287,1258,1230,
		1202,1174,1147,1120,1095,1069,1044,1020,996,972,
		949,927,905,884,863,842,822,803,783,765,
		746,729,711,694,677,661,645,630,615,600,
		586,572,558,545,532,519,507,495,483,471,
		460,449,439,428,418,408,399,390,381,372,
		363,355,347,339,331,323};
		if (i > 8'd145) return t[145];
		return t[i];
	endfunction
endpackage
`default_nettype wire

>>> rtl/core/tcm_stream_if.sv
`default_nettype none
interface tcm_stream_if #(parameter int W = 1);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/tcm_front.sv
`default_nettype none
// accumulates a group and emits its trimmed mean
module tcm_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [tcm_pkg::ChanW-1:0] channel,
	input wire logic [tcm_pkg::SampleW-1:0] sample,
	input wire logic monitor_armed,
	output logic q_valid,
	input wire logic q_ready,
	output tcm_pkg::group_t q_data
);
	logic [tcm_pkg::SumW-1:0] sum_q;
	logic [tcm_pkg::SampleW-1:0] max_q, min_q;
	logic [4:0] idx_q;
	logic [tcm_pkg::SumW-1:0] sum_n, trim;
	logic [tcm_pkg::SampleW-1:0] max_n, min_n;
	logic first, last;

	assign in_ready = !q_valid || q_ready;
	assign first = (idx_q == 5'd0);
	assign last = (idx_q == 5'(tcm_pkg::SamplesPerReading - 1));
	always_comb begin
		sum_n = first ? tcm_pkg::SumW'(sample) : sum_q + tcm_pkg::SumW'(sample);
		max_n = (first || sample > max_q) ? sample : max_q;
		min_n = (first || sample < min_q) ? sample : min_q;
		trim = sum_n - tcm_pkg::SumW'(max_n) - tcm_pkg::SumW'(min_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			q_valid <= 1'b0;
			sum_q <= '0;
			max_q <= '0;
			min_q <= '0;
		end else begin
			if (q_valid && q_ready) q_valid <= 1'b0;
			if (in_valid && in_ready) begin
				sum_q <= sum_n;
				max_q <= max_n;
				min_q <= min_n;
				if (last) begin
					idx_q <= '0;
					q_valid <= 1'b1;
				end else begin
					idx_q <= idx_q + 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready && last) begin
			q_data.channel <= channel;
			q_data.armed <= monitor_armed;
			q_data.mean <= trim[15:4];
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/tcm_back.sv
`default_nettype none
// sequential table search, bit-serial divide, rise tracking
module tcm_back #(parameter int CHANNEL_COUNT = tcm_pkg::ChannelCount) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	output logic q_ready,
	input wire tcm_pkg::group_t q_data,
	input wire logic [10:0] thr,
	input wire logic [7:0] lim,
	input wire logic [7:0] mask,
	output logic out_valid,
	input wire logic out_ready,
	output logic [2:0] out_channel,
	output logic [11:0] temperature,
	output logic [11:0] trimmed_average,
	output logic abnormal
);
	localparam logic [2:0] StIdle = 3'd0, StSearch = 3'd1, StDiv = 3'd2,
		StRise = 3'd3, StOut = 3'd4;
	localparam int CiW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
	logic [2:0] st_q;
	tcm_pkg::group_t g_q;
	logic [7:0] i_q;
	logic [3:0] dcnt_q;
	logic [11:0] span_q;
	logic [11:0] rem_q;
	logic [3:0] quo_q;
	logic signed [11:0] temp_q;
	logic signed [11:0] prev_q [CHANNEL_COUNT];
	logic [7:0] cnt_q [CHANNEL_COUNT];
	logic [CHANNEL_COUNT-1:0] flag_q;
	logic [11:0] ent, entp;
	logic [12:0] trial;
	logic valid_ch;
	logic [CiW-1:0] ci;
	logic signed [12:0] diff;
	logic [7:0] cinc;

	assign ent = tcm_pkg::ntc_entry(i_q);
	assign entp = tcm_pkg::ntc_entry(i_q - 8'd1);
	assign trial = {1'b0, rem_q} - {1'b0, span_q};
	assign valid_ch = 32'(g_q.channel) < CHANNEL_COUNT;
	assign ci = valid_ch ? CiW'(g_q.channel) : '0;
	assign diff = 13'(temp_q) - 13'(prev_q[ci]);
	assign cinc = cnt_q[ci] + 8'd1;
	assign q_ready = (st_q == StIdle);
	assign out_valid = (st_q == StOut);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= StIdle;
			flag_q <= '0;
			for (int c = 0; c < CHANNEL_COUNT; c++) begin
				prev_q[c] <= '0;
				cnt_q[c] <= '0;
			end
			i_q <= '0; dcnt_q <= '0; span_q <= '0; rem_q <= '0; quo_q <= '0;
			temp_q <= '0; g_q <= '0;
		end else begin
			unique case (st_q)
				StIdle: if (q_valid) begin
					g_q <= q_data;
					i_q <= 8'd1;
					if (q_data.mean <= 12'd323) begin
						temp_q <= tcm_pkg::TempHot; st_q <= StRise;
					end else if (q_data.mean >= 12'd3894) begin
						temp_q <= tcm_pkg::TempCold; st_q <= StRise;
					end else st_q <= StSearch;
				end
				StSearch: if (g_q.mean > ent) begin
					// divisor starts at eight times the span
					span_q <= {1'b0, 8'(entp - ent), 3'd0};
					rem_q <= 12'(g_q.mean - ent);
					quo_q <= '0;
					dcnt_q <= 4'd0;
					st_q <= StDiv;
				end else i_q <= i_q + 8'd1;
				StDiv: begin
					if (dcnt_q == 4'd0) begin
						rem_q <= 12'((rem_q << 3) + (rem_q << 1));
						dcnt_q <= 4'd1;
					end else begin
						// restoring divide, 4 quotient bits
						if (!trial[12]) begin
							rem_q <= trial[11:0];
							quo_q <= {quo_q[2:0], 1'b1};
						end else begin
							quo_q <= {quo_q[2:0], 1'b0};
						end
						span_q <= span_q >> 1;
						if (dcnt_q == 4'd4) begin
							st_q <= StRise;
						end
						dcnt_q <= dcnt_q + 4'd1;
					end
				end
				StRise: st_q <= StOut;
				StOut: if (out_ready) st_q <= StIdle;
				default: st_q <= StIdle;
			endcase
			if (st_q == StDiv && dcnt_q == 4'd4) begin
				temp_q <= 12'(12'(i_q) * 12'd10 - 12'({quo_q[2:0], !trial[12]}) - 12'd400);
			end
			if (st_q == StRise && valid_ch) begin
				if (g_q.armed && mask[g_q.channel] && diff > 13'sd0) begin
					if (diff >= $signed({2'b0, thr})) begin
						if (cinc == lim) begin
							flag_q[ci] <= 1'b1;
							cnt_q[ci] <= '0;
						end else cnt_q[ci] <= cinc;
					end else cnt_q[ci] <= '0;
				end
				prev_q[ci] <= temp_q;
			end
		end
	end

	// the divide scales the remainder by ten, then compares it against the
	// span times 8, 4, 2 and 1: numerator at most 10*span, quotient at most 10
	assign out_channel = g_q.channel;
	assign temperature = temp_q;
	assign trimmed_average = g_q.mean;
	assign abnormal = valid_ch ? flag_q[ci] : 1'b0;
endmodule
`default_nettype wire

>>> rtl/core/thermistor_channel_monitor.sv
`default_nettype none
// thermistor channel monitor
// in channel: one beat per raw sample (channel, sample, monitor_armed);
// every 18 beats complete a group. the front accumulates sum, max and min
// one beat per cycle while its one-entry queue has room, and hands the
// trimmed mean to that queue. the back walks the ntc table one entry per
// cycle (up to 145 entries), then scales the remainder by ten, divides
// bit-serially and updates per-channel rise state; it takes no new group
// until its result beat has been taken. throughput: one sample per cycle
// while the queue has room; a long lookup holds the input once the next
// group waits in the queue.
// out channel: one beat per group, held until out.ready.
// reset clears the accumulator, all per-channel state and the registers
// to 20, 3 and 31. a stalled receiver stalls the back, then the queue,
// then the input channel.
// apb: 0x0 rise_threshold, 0x4 rise_count_limit, 0x8 rise_channel_mask
module thermistor_channel_monitor #(
	parameter int CHANNEL_COUNT = tcm_pkg::ChannelCount
) (
	input wire logic clk,
	input wire logic arst_n,
	tcm_stream_if.sink in_ch,
	tcm_stream_if.source out_ch,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [3:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic [10:0] thr_q;
	logic [7:0] lim_q, mask_q;
	logic qv, qr;
	tcm_pkg::group_t qd;
	logic [2:0] oc;
	logic [11:0] ot, oa;
	logic ob;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 11'd20; lim_q <= 8'd3; mask_q <= 8'd31;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				tcm_pkg::RegThreshold: thr_q <= pwdata[10:0];
				tcm_pkg::RegLimit: lim_q <= pwdata[7:0];
				tcm_pkg::RegMask: mask_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		unique case (paddr[3:2])
			tcm_pkg::RegThreshold: prdata = {21'd0, thr_q};
			tcm_pkg::RegLimit: prdata = {24'd0, lim_q};
			tcm_pkg::RegMask: prdata = {24'd0, mask_q};
			default: prdata = '0;
		endcase
	end

	tcm_front u_front (.clk, .arst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.channel(in_ch.data[15:13]), .sample(in_ch.data[12:1]),
		.monitor_armed(in_ch.data[0]), .q_valid(qv), .q_ready(qr), .q_data(qd));

	tcm_back #(.CHANNEL_COUNT(CHANNEL_COUNT)) u_back (.clk, .arst_n, .q_valid(qv),
		.q_ready(qr), .q_data(qd), .thr(thr_q), .lim(lim_q), .mask(mask_q),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_channel(oc),
		.temperature(ot), .trimmed_average(oa), .abnormal(ob));

	assign out_ch.data = {oc, ot, oa, ob};
endmodule
`default_nettype wire
